// File: rtl/spq_pkg.sv
// Package: constants, codes and types shared by the sorted priority queue files.
package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int OCC_W   = 5;
  localparam int ERR_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  localparam logic signed [VALUE_W-1:0] EMPTY_HEAD = -32'sd1;

  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] val;
  } cell_cmd_t;

endpackage

// File: rtl/spq_if.sv
// Interfaces: request and response channels of the sorted priority queue.
interface spq_req_if;
  logic                               valid;
  logic                               ready;
  logic [spq_pkg::REQ_W-1:0]          req_type;
  logic signed [spq_pkg::VALUE_W-1:0] item_value;
  logic [spq_pkg::PRIO_W-1:0]         item_priority;

  modport source(output valid, req_type, item_value, item_priority, input ready);
  modport sink(input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [spq_pkg::VALUE_W-1:0] head_value;
  logic                               not_empty;
  logic [spq_pkg::OCC_W-1:0]          occupancy;
  logic [spq_pkg::ERR_W-1:0]          error_code;

  modport source(output valid, head_value, not_empty, occupancy, error_code, input ready);
  modport sink(input valid, head_value, not_empty, occupancy, error_code, output ready);
endinterface

// File: rtl/spq_cell.sv
// Cell: one slot of the sorted shift register, shifts toward tail or head.
module spq_cell #(
  parameter int PW = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                               clk,
  input  spq_pkg::cell_cmd_t                 cmd,
  input  logic                               occupied,
  input  logic                               prev_below,
  input  logic signed [spq_pkg::VALUE_W-1:0] prev_val,
  input  logic [PW-1:0]                      prev_prio,
  input  logic signed [spq_pkg::VALUE_W-1:0] next_val,
  input  logic [PW-1:0]                      next_prio,
  output logic signed [spq_pkg::VALUE_W-1:0] val,
  output logic [PW-1:0]                      prio,
  output logic                               below
);

  logic signed [spq_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [PW-1:0]                      prio_r, prio_nxt;

  // new entry goes at or above this slot
  assign below = !(occupied && (prio_r >= cmd.prio[PW-1:0]));

  always_comb begin
    val_nxt  = val_r;
    prio_nxt = prio_r;
    if (cmd.enq && below) begin
      if (prev_below) begin
        val_nxt  = prev_val;
        prio_nxt = prev_prio;
      end else begin
        val_nxt  = cmd.val;
        prio_nxt = cmd.prio[PW-1:0];
      end
    end else if (cmd.deq) begin
      val_nxt  = next_val;
      prio_nxt = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prio_r <= prio_nxt;
  end

  assign val  = val_r;
  assign prio = prio_r;

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of cells kept in priority order, head at cell 0.
// The response beat is registered in the cycle after its accepted request beat.
// Throughput: one request per cycle; every cell compares and shifts in parallel.
// A response waiting in the output register holds off input only while not taken.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
module sorted_priority_queue_unit #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_req_if.sink    in_ch,
  spq_rsp_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (PRIORITY_BITS < spq_pkg::PRIO_W) ? PRIORITY_BITS : spq_pkg::PRIO_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic signed [spq_pkg::VALUE_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] occ_r;
  spq_pkg::err_t    err_r, err_nxt;

  logic accept, full, empty, do_enq, do_deq;
  spq_pkg::cell_cmd_t cmd;

  logic signed [spq_pkg::VALUE_W-1:0] cell_val   [CAPACITY];
  logic [PW-1:0]                      cell_prio  [CAPACITY];
  logic                               cell_below [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);
  assign do_enq      = accept && (in_ch.req_type == spq_pkg::REQ_ENQUEUE) && !full;
  assign do_deq      = accept && (in_ch.req_type == spq_pkg::REQ_DEQUEUE) && !empty;

  always_comb begin
    cmd      = '0;
    cmd.enq  = do_enq;
    cmd.deq  = do_deq;
    cmd.prio = in_ch.item_priority & spq_pkg::PRIO_W'((64'd1 << PW) - 64'd1);
    cmd.val  = in_ch.item_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               pb;
    logic signed [spq_pkg::VALUE_W-1:0] pv, nv;
    logic [PW-1:0]                      pp, np;

    if (i == 0) begin : g_first
      assign pb = 1'b0;
      assign pv = '0;
      assign pp = '0;
    end else begin : g_mid
      assign pb = cell_below[i-1];
      assign pv = cell_val[i-1];
      assign pp = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nv = '0;
      assign np = '0;
    end else begin : g_body
      assign nv = cell_val[i+1];
      assign np = cell_prio[i+1];
    end

    spq_cell #(.PW(PW)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (count_r > CNT_W'(i)),
      .prev_below(pb),
      .prev_val  (pv),
      .prev_prio (pp),
      .next_val  (nv),
      .next_prio (np),
      .val       (cell_val[i]),
      .prio      (cell_prio[i]),
      .below     (cell_below[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    err_nxt   = spq_pkg::ERR_OK;
    head_nxt  = cell_val[0];
    if (do_enq) begin
      count_nxt = count_r + CNT_W'(1);
      if (cell_below[0]) begin
        head_nxt = in_ch.item_value;
      end
    end else if (do_deq) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = cell_val[1];
    end
    if (accept && (in_ch.req_type == spq_pkg::REQ_ENQUEUE) && full) begin
      err_nxt = spq_pkg::ERR_FULL;
    end
    if (accept && (in_ch.req_type == spq_pkg::REQ_DEQUEUE) && empty) begin
      err_nxt = spq_pkg::ERR_EMPTY;
    end
    if (count_nxt == '0) begin
      head_nxt = spq_pkg::EMPTY_HEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
      occ_r  <= count_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.head_value = head_r;
  assign out_ch.not_empty  = (occ_r != '0);
  assign out_ch.occupancy  = spq_pkg::OCC_W'(occ_r);
  assign out_ch.error_code = err_r;

endmodule

// File: rtl/spq_checker.sv
// Checker: port-level properties of the sorted priority queue, bound to the top.
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [spq_pkg::VALUE_W-1:0] head_value,
  input logic                               not_empty,
  input logic [spq_pkg::OCC_W-1:0]          occupancy,
  input logic [spq_pkg::ERR_W-1:0]          error_code
);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY >= 32) || (int'(occupancy) <= CAPACITY)))
    else $error("occupancy above capacity");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !not_empty) |-> (head_value == spq_pkg::EMPTY_HEAD))
    else $error("empty queue must report head -1");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (error_code == spq_pkg::ERR_OK || error_code == spq_pkg::ERR_EMPTY ||
                   error_code == spq_pkg::ERR_FULL))
    else $error("unknown error code");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && error_code == spq_pkg::ERR_EMPTY) |-> (!not_empty && occupancy == '0))
    else $error("dequeue on empty with entries held");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(head_value) && $stable(error_code)))
    else $error("stalled response beat changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .head_value(out_ch.head_value),
  .not_empty (out_ch.not_empty),
  .occupancy (out_ch.occupancy),
  .error_code(out_ch.error_code)
);
